// ===== src/gfsr_pkg.sv =====
package gfsr_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET     = 3'd0,
      CSR_STOP       = 3'd1,
      CSR_CONTACT    = 3'd2,
      CSR_TOLERANCE  = 3'd3,
      CSR_SETTLE     = 3'd4,
      CSR_RECORD     = 3'd5,
      CSR_START_POS  = 3'd6,
      CSR_START_STEP = 3'd7
   } csr_index_type;

   localparam logic [16:0] TARGET_RST     = 17'd5000;
   localparam logic [18:0] STOP_RST       = 19'h7C568;   // -15000
   localparam logic [18:0] CONTACT_RST    = 19'h7FE0C;   // -500
   localparam logic [13:0] TOLERANCE_RST  = 14'd10;
   localparam logic [15:0] SETTLE_RST     = 16'd300;
   localparam logic [15:0] RECORD_RST     = 16'd500;
   localparam logic [30:0] START_POS_RST  = 31'd20000000;
   localparam logic [21:0] START_STEP_RST = 22'd3000000;

   localparam logic [21:0] STEP_FLOOR     = 22'd1000;
   localparam logic [21:0] STEP_DIVISOR   = 22'd10;
   localparam int          RECIP_SHIFT    = 26;
   localparam logic [22:0] RECIP_10       = 23'((64'd1 << RECIP_SHIFT) / 64'd10);
   localparam logic [29:0] GAIN           = 30'd1000;

   // |diff| * 1000 stays below 2**29
   localparam int DIV_STEPS = 29;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      STAT_APPROACH = 3'd0,
      STAT_REGULATE = 3'd1,
      STAT_GOAL     = 3'd2,
      STAT_REC_WAIT = 3'd3,
      STAT_RECORD   = 3'd4,
      STAT_ESTOP    = 3'd5,
      STAT_END      = 3'd6,
      STAT_HALTED   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CL_HALT,
      CL_ESTOP,
      CL_APPROACH,
      CL_REGULATE,
      CL_RECORD
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic signed [19:0] force_req;
      logic signed [15:0] accel_a;
      logic signed [15:0] accel_b;
      logic signed [15:0] accel_c;
      logic signed [15:0] accel_d;
      logic signed [15:0] accel_e;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] position_cmd;
      logic               cmd_valid;
      logic               rec_valid;
      logic signed [15:0] rec_a;
      logic signed [15:0] rec_b;
      logic signed [15:0] rec_c;
      logic signed [15:0] rec_d;
      logic signed [15:0] rec_e;
      logic               finished;
   } rsp_word_type;

   typedef struct packed {
      logic cap;
      logic prep;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_sts_type;

endpackage

// ===== src/gripper_force_seek_regulator.sv =====
// Force-seeking gripper regulator. Each request word carries one force sample
// and five accelerometer samples and yields exactly one response word with the
// status, the commanded position and, while recording, the passed-on samples.
// A word is taken only in the idle state; each tick then passes through prep and
// commit, and a regulate tick also runs the 29-step restoring divider that
// forms 1000*(|f|-|target|)/|target| between the two; all other ticks skip it. The
// response sits in an output register, so the next word is taken while the
// previous response waits. Configuration writes are expected only while idle;
// writing the start position or start approach step loads it at once.
module gripper_force_seek_regulator import gfsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   gfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gfsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/gfsr_ctrl.sv =====
module gfsr_ctrl import gfsr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = sts.need_div ? ST_DIV : ST_COMMIT;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/gfsr_dp.sv =====
module gfsr_dp import gfsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_sts_type            sts,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_word_type          req_data,
   output rsp_word_type          rsp_data
);

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh0_7FFF_FFFF;
      lo = -34'sh0_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // configuration
   logic        [16:0] target_ff;
   logic signed [18:0] stop_ff;
   logic signed [18:0] contact_ff;
   logic        [13:0] tol_ff;
   logic        [15:0] settle_ff;
   logic        [15:0] rec_len_ff;

   // regulator state
   logic signed [31:0] position_ff, position_in;
   logic        [21:0] step_ff, step_in;
   logic        [15:0] settled_ff, settled_in;
   logic               rec_phase_ff, rec_phase_in;
   logic               armed_ff, armed_in;
   logic        [15:0] rec_cnt_ff, rec_cnt_in;
   logic               halted_ff, halted_in;

   // word and intermediate registers
   req_word_type       in_ff;
   class_type          class_ff, class_c;
   logic               neg_ff;
   logic        [19:0] absdiff_ff;
   logic               sum_zero_ff;
   logic        [16:0] divisor_ff;
   logic        [18:0] step_q0_ff;
   logic        [DIV_STEPS-1:0] quo_ff, quo_in;
   logic        [16:0] rem_ff, rem_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic signed [19:0] force_c;
   logic        [19:0] af_c;
   logic        [16:0] at_c;
   logic signed [20:0] diff_c;
   logic        [19:0] absdiff_c;
   logic signed [18:0] sum_c;
   logic        [29:0] scaled_c;
   logic        [44:0] recip_c;
   logic        [17:0] trial_c;

   logic signed [33:0] pos_ext_c;
   logic signed [33:0] q_ext_c;
   logic        [21:0] q0_c;
   logic        [21:0] ten_q_c;
   logic        [21:0] rem10_c;
   logic        [21:0] step_div_c;
   logic        [15:0] settled_new_c;
   logic        [15:0] cnt_new_c;
   logic               arm_c;
   logic               recv_c;

   // classification and prep arithmetic
   always_comb begin
      force_c   = in_ff.force_req;
      af_c      = force_c[19] ? 20'(-force_c) : 20'(force_c);
      at_c      = (target_ff == '0) ? 17'd1 : target_ff;
      diff_c    = $signed({1'b0, af_c}) - $signed({4'b0, at_c});
      absdiff_c = diff_c[20] ? 20'(-diff_c) : diff_c[19:0];
      scaled_c  = 30'(absdiff_c) * GAIN;
      sum_c     = 19'(in_ff.accel_a) + 19'(in_ff.accel_b) + 19'(in_ff.accel_c)
                + 19'(in_ff.accel_d) + 19'(in_ff.accel_e);
      recip_c   = 45'(step_ff) * 45'(RECIP_10);
      if (halted_ff) begin
         class_c = CL_HALT;
      end else if (force_c < 20'(stop_ff)) begin
         class_c = CL_ESTOP;
      end else if (force_c > 20'(contact_ff)) begin
         class_c = CL_APPROACH;
      end else if (!rec_phase_ff) begin
         class_c = CL_REGULATE;
      end else begin
         class_c = CL_RECORD;
      end
      sts.need_div = (class_c == CL_REGULATE);
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial_c = {rem_ff, quo_ff[DIV_STEPS-1]};
      if (trial_c >= {1'b0, divisor_ff}) begin
         rem_in = 17'(trial_c - {1'b0, divisor_ff});
         quo_in = {quo_ff[DIV_STEPS-2:0], 1'b1};
      end else begin
         rem_in = trial_c[16:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         in_ff <= req_data;
      end
      if (cmd.prep) begin
         class_ff    <= class_c;
         neg_ff      <= diff_c[20];
         absdiff_ff  <= absdiff_c;
         sum_zero_ff <= (sum_c == '0);
         divisor_ff  <= at_c;
         step_q0_ff  <= recip_c[RECIP_SHIFT+18:RECIP_SHIFT];
         quo_ff      <= scaled_c[DIV_STEPS-1:0];
         rem_ff      <= '0;
      end else if (cmd.step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // tick update
   always_comb begin
      pos_ext_c     = 34'(position_ff);
      q_ext_c       = neg_ff ? -$signed(34'(quo_ff)) : $signed(34'(quo_ff));
      q0_c          = 22'(step_q0_ff);
      ten_q_c       = (q0_c << 3) + (q0_c << 1);
      rem10_c       = step_ff - ten_q_c;
      step_div_c    = (rem10_c >= STEP_DIVISOR) ? q0_c + 1'b1 : q0_c;
      settled_new_c = settled_ff;
      if ((absdiff_ff <= 20'(tol_ff)) && (settled_ff != 16'hFFFF)) begin
         settled_new_c = settled_ff + 1'b1;
      end
      cnt_new_c     = rec_cnt_ff + 1'b1;
      arm_c         = sum_zero_ff || armed_ff;

      position_in  = position_ff;
      step_in      = step_ff;
      settled_in   = settled_ff;
      rec_phase_in = rec_phase_ff;
      armed_in     = armed_ff;
      rec_cnt_in   = rec_cnt_ff;
      halted_in    = halted_ff;
      recv_c       = 1'b0;

      rsp_in           = '0;
      rsp_in.status    = STAT_HALTED;

      case (class_ff)
         CL_HALT: begin
            rsp_in.status = STAT_HALTED;
         end
         CL_ESTOP: begin
            halted_in     = 1'b1;
            rsp_in.status = STAT_ESTOP;
         end
         CL_APPROACH: begin
            position_in      = sat32(pos_ext_c - 34'(step_ff));
            step_in          = (step_ff > STEP_FLOOR) ? step_div_c : STEP_FLOOR;
            rsp_in.status    = STAT_APPROACH;
            rsp_in.cmd_valid = 1'b1;
         end
         CL_REGULATE: begin
            position_in      = sat32(pos_ext_c + q_ext_c);
            settled_in       = settled_new_c;
            rsp_in.cmd_valid = 1'b1;
            if (settled_new_c >= settle_ff) begin
               rec_phase_in  = 1'b1;
               rsp_in.status = STAT_GOAL;
            end else begin
               rsp_in.status = STAT_REGULATE;
            end
         end
         CL_RECORD: begin
            rec_cnt_in = cnt_new_c;
            if (arm_c) begin
               armed_in = 1'b1;
               recv_c   = 1'b1;
               if (cnt_new_c == rec_len_ff) begin
                  halted_in     = 1'b1;
                  rsp_in.status = STAT_END;
               end else begin
                  rsp_in.status = STAT_RECORD;
               end
            end else begin
               rsp_in.status = STAT_REC_WAIT;
            end
         end
         default: begin
            rsp_in.status = STAT_HALTED;
         end
      endcase

      rsp_in.position_cmd = position_in;
      rsp_in.rec_valid    = recv_c;
      rsp_in.finished     = halted_in;
      if (recv_c) begin
         rsp_in.rec_a = in_ff.accel_a;
         rsp_in.rec_b = in_ff.accel_b;
         rsp_in.rec_c = in_ff.accel_c;
         rsp_in.rec_d = in_ff.accel_d;
         rsp_in.rec_e = in_ff.accel_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RST;
         stop_ff      <= STOP_RST;
         contact_ff   <= CONTACT_RST;
         tol_ff       <= TOLERANCE_RST;
         settle_ff    <= SETTLE_RST;
         rec_len_ff   <= RECORD_RST;
         position_ff  <= 32'(START_POS_RST);
         step_ff      <= START_STEP_RST;
         settled_ff   <= '0;
         rec_phase_ff <= 1'b0;
         armed_ff     <= 1'b0;
         rec_cnt_ff   <= '0;
         halted_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET:     target_ff   <= csr_wdata[16:0];
            CSR_STOP:       stop_ff     <= csr_wdata[18:0];
            CSR_CONTACT:    contact_ff  <= csr_wdata[18:0];
            CSR_TOLERANCE:  tol_ff      <= csr_wdata[13:0];
            CSR_SETTLE:     settle_ff   <= csr_wdata[15:0];
            CSR_RECORD:     rec_len_ff  <= csr_wdata[15:0];
            CSR_START_POS:  position_ff <= 32'(csr_wdata);
            CSR_START_STEP: step_ff     <= csr_wdata[21:0];
            default: ;
         endcase
      end else if (cmd.commit) begin
         position_ff  <= position_in;
         step_ff      <= step_in;
         settled_ff   <= settled_in;
         rec_phase_ff <= rec_phase_in;
         armed_ff     <= armed_in;
         rec_cnt_ff   <= rec_cnt_in;
         halted_ff    <= halted_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/gfsr_checker.sv =====
module gfsr_checker import gfsr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // one word in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_cmd_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cmd_valid == (rsp_data.status == STAT_APPROACH ||
                                           rsp_data.status == STAT_REGULATE ||
                                           rsp_data.status == STAT_GOAL))
      else $error("cmd_valid disagrees with status");

   a_finish_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_ESTOP || rsp_data.status == STAT_END ||
                    rsp_data.status == STAT_HALTED) |-> rsp_data.finished)
      else $error("stop or end without finished");

   a_rec_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rec_valid |->
         (rsp_data.status == STAT_RECORD || rsp_data.status == STAT_END))
      else $error("samples passed outside recording");

endmodule

bind gripper_force_seek_regulator gfsr_checker u_gfsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
